[sv/vau_pkg.sv]
// types, codes and helpers shared by the vector arithmetic unit
package vau_pkg;

  typedef enum logic [3:0] {
    MODE_ADD   = 4'd0,
    MODE_SUB   = 4'd1,
    MODE_DOT   = 4'd2,
    MODE_CROSS = 4'd3,
    MODE_SCALE = 4'd4,
    MODE_DIV   = 4'd5,
    MODE_MAG   = 4'd6,
    MODE_UNIT  = 4'd7,
    MODE_PROJ  = 4'd8,
    MODE_PERP  = 4'd9
  } mode_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // one root bit per stage, one quotient bit per stage
  localparam int SQ_STEPS = 32;
  localparam int QBITS    = 33;

  typedef struct packed {
    logic        ov;
    logic [31:0] val;
  } sat_t;

  typedef struct packed {
    logic [3:0]       mode;
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    logic [2:0][31:0] am;
    logic [2:0][31:0] bm;
    logic [2:0]       an;
    logic [2:0]       bn;
    logic             fn;
    logic [31:0]      fm;
  } s1_t;

  typedef struct packed {
    logic [3:0]       mode;
    logic [5:0][63:0] p;
    logic [5:0]       pn;
    logic [2:0][32:0] asum;
    logic [2:0][31:0] a;
    logic [2:0][31:0] am;
    logic [2:0][31:0] bm;
    logic [2:0]       an;
    logic [2:0]       bn;
    logic             fn;
    logic [31:0]      fm;
  } s2_t;

  typedef struct packed {
    logic [3:0]       mode;
    logic [2:0][65:0] v;
    logic [65:0]      dsum;
    logic [63:0]      sa;
    logic [63:0]      nb;
    logic [2:0][32:0] asum;
    logic [2:0][31:0] a;
    logic [2:0][31:0] am;
    logic [2:0][31:0] bm;
    logic [2:0]       an;
    logic [2:0]       bn;
    logic             fn;
    logic [31:0]      fm;
  } s3_t;

  typedef struct packed {
    logic [3:0]       mode;
    logic [3:0][31:0] res;
    logic             ov;
    logic [2:0][31:0] a;
    logic [2:0][31:0] am;
    logic [2:0][31:0] bm;
    logic [2:0]       an;
    logic [2:0]       bn;
    logic             fn;
    logic [31:0]      fm;
    logic             dneg;
    logic [63:0]      dmag;
    logic [63:0]      nb;
  } ctx_t;

  typedef struct packed {
    ctx_t        c;
    logic [63:0] x;
    logic [63:0] r;
  } sq_t;

  typedef struct packed {
    ctx_t             c;
    logic [32:0]      len;
    logic [2:0][63:0] pplo;
    logic [2:0][63:0] pphi;
  } m1_t;

  typedef struct packed {
    logic [3:0]       mode;
    logic [3:0][31:0] res;
    logic             ov;
    logic [2:0][31:0] a;
    logic             divop;
    logic             dz;
    logic [2:0]       sgn;
    logic [2:0][95:0] num;
    logic [63:0]      den;
  } m2_t;

  typedef struct packed {
    logic [3:0]             mode;
    logic [3:0][31:0]       res;
    logic                   ov;
    logic [2:0][31:0]       a;
    logic                   divop;
    logic                   dz;
    logic [2:0]             sgn;
    logic [2:0]             big;
    logic [2:0][63:0]       rem;
    logic [2:0][QBITS-1:0]  qw;
    logic [63:0]            den;
  } dv_t;

  typedef struct packed {
    logic [3:0][31:0] r;
    logic [1:0]       status;
  } res_t;

  function automatic sat_t sat32(input logic [65:0] v);
    sat_t s;
    s.ov  = 1'b0;
    s.val = v[31:0];
    if (!v[65] && (v[64:31] != '0)) begin
      s.ov  = 1'b1;
      s.val = 32'h7FFF_FFFF;
    end else if (v[65] && (v[64:31] != '1)) begin
      s.ov  = 1'b1;
      s.val = 32'h8000_0000;
    end
    return s;
  endfunction

endpackage

[sv/vau_in_if.sv]
// input channel of the vector arithmetic unit
interface vau_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         mode;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] a_z;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] b_z;
  logic signed [31:0] factor;

  modport source (output valid, mode, a_x, a_y, a_z, b_x, b_y, b_z, factor, input ready);
  modport sink (input valid, mode, a_x, a_y, a_z, b_x, b_y, b_z, factor, output ready);
endinterface

[sv/vau_out_if.sv]
// result channel of the vector arithmetic unit
interface vau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] r_x;
  logic signed [31:0] r_y;
  logic signed [31:0] r_z;
  logic signed [31:0] r_scalar;
  logic [1:0]         status;

  modport source (output valid, r_x, r_y, r_z, r_scalar, status, input ready);
  modport sink (input valid, r_x, r_y, r_z, r_scalar, status, output ready);
endinterface

[sv/vector3_arithmetic_unit.sv]
// 3d vector unit: add, sub, dot, cross, scale, divide, magnitude, unit, project, perpendicular
//
// in_ch carries one item per handshake: mode, vectors a and b, and factor, all
// signed fixed point with FRAC_BITS fraction bits. out_ch returns one item per
// input item, in order: vector r, scalar r_scalar and status (ok, division by
// zero, saturated).
// Every mode takes the same path from the accepting edge to out_ch.valid.
// Throughput is one item per cycle while out_ch takes results. The depth
// comes from the square root (32 stages, one root bit each) followed by the
// restoring divider (33 stages, one quotient bit each), plus multiply, sum,
// setup and output stages.
// The whole pipeline advances together; it holds only when the output
// register holds an item that out_ch does not take. Then in_ch.ready is low
// and every stage keeps its item. Bubbles travel as cleared valid bits.
// Reset (synchronous, rst_n low) clears all valid bits; no item is lost or
// invented across a stall.
module vector3_arithmetic_unit
  import vau_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  vau_in_if.sink   in_ch,
  vau_out_if.source out_ch
);

  localparam int V_SQ0 = 4;
  localparam int V_M1  = V_SQ0 + SQ_STEPS;
  localparam int V_M3  = V_M1 + 2;
  localparam int V_DL  = V_M3 + QBITS;
  localparam int NST   = V_DL + 2;

  logic [NST-1:0] vld_r;
  logic           adv;

  s1_t  s1_nxt, s1_r;
  s2_t  s2_nxt, s2_r;
  s3_t  s3_nxt, s3_r;
  sq_t  sq_in_nxt, sq_in_r;
  sq_t  sq_nxt [SQ_STEPS];
  sq_t  sq_r   [SQ_STEPS];
  m1_t  m1_nxt, m1_r;
  m2_t  m2_nxt, m2_r;
  dv_t  m3_nxt, m3_r;
  dv_t  dv_nxt [QBITS];
  dv_t  dv_r   [QBITS];
  res_t out_nxt, out_r;

  logic [5:0][31:0] mx, my;
  logic [5:0]       mn;

  assign adv         = !vld_r[NST-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_ch.valid};
    end
  end

  // input stage: sign and magnitude
  always_comb begin
    s1_nxt.mode = in_ch.mode;
    s1_nxt.a    = {in_ch.a_z, in_ch.a_y, in_ch.a_x};
    s1_nxt.b    = {in_ch.b_z, in_ch.b_y, in_ch.b_x};
    for (int i = 0; i < 3; i++) begin
      s1_nxt.an[i] = s1_nxt.a[i][31];
      s1_nxt.bn[i] = s1_nxt.b[i][31];
      s1_nxt.am[i] = s1_nxt.an[i] ? -s1_nxt.a[i] : s1_nxt.a[i];
      s1_nxt.bm[i] = s1_nxt.bn[i] ? -s1_nxt.b[i] : s1_nxt.b[i];
    end
    s1_nxt.fn = in_ch.factor[31];
    s1_nxt.fm = s1_nxt.fn ? -in_ch.factor : in_ch.factor;
  end

  // product stage: six shared multipliers
  always_comb begin
    mx = '0;
    my = '0;
    mn = '0;
    unique case (s1_r.mode)
      MODE_DOT, MODE_PROJ, MODE_PERP: begin
        for (int i = 0; i < 3; i++) begin
          mx[i]   = s1_r.am[i];
          my[i]   = s1_r.bm[i];
          mn[i]   = s1_r.an[i] ^ s1_r.bn[i];
          mx[3+i] = s1_r.bm[i];
          my[3+i] = s1_r.bm[i];
        end
      end
      MODE_CROSS: begin
        mx[0] = s1_r.am[1]; my[0] = s1_r.bm[2]; mn[0] = s1_r.an[1] ^ s1_r.bn[2];
        mx[1] = s1_r.am[2]; my[1] = s1_r.bm[1]; mn[1] = s1_r.an[2] ^ s1_r.bn[1];
        mx[2] = s1_r.am[2]; my[2] = s1_r.bm[0]; mn[2] = s1_r.an[2] ^ s1_r.bn[0];
        mx[3] = s1_r.am[0]; my[3] = s1_r.bm[2]; mn[3] = s1_r.an[0] ^ s1_r.bn[2];
        mx[4] = s1_r.am[0]; my[4] = s1_r.bm[1]; mn[4] = s1_r.an[0] ^ s1_r.bn[1];
        mx[5] = s1_r.am[1]; my[5] = s1_r.bm[0]; mn[5] = s1_r.an[1] ^ s1_r.bn[0];
      end
      MODE_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          mx[i] = s1_r.am[i];
          my[i] = s1_r.fm;
          mn[i] = s1_r.an[i] ^ s1_r.fn;
        end
      end
      MODE_MAG, MODE_UNIT: begin
        for (int i = 0; i < 3; i++) begin
          mx[i] = s1_r.am[i];
          my[i] = s1_r.am[i];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    s2_nxt.mode = s1_r.mode;
    for (int k = 0; k < 6; k++) begin
      s2_nxt.p[k] = {32'd0, mx[k]} * {32'd0, my[k]};
    end
    s2_nxt.pn = mn;
    for (int i = 0; i < 3; i++) begin
      if (s1_r.mode == MODE_SUB) begin
        s2_nxt.asum[i] = {s1_r.a[i][31], s1_r.a[i]} - {s1_r.b[i][31], s1_r.b[i]};
      end else begin
        s2_nxt.asum[i] = {s1_r.a[i][31], s1_r.a[i]} + {s1_r.b[i][31], s1_r.b[i]};
      end
    end
    s2_nxt.a  = s1_r.a;
    s2_nxt.am = s1_r.am;
    s2_nxt.bm = s1_r.bm;
    s2_nxt.an = s1_r.an;
    s2_nxt.bn = s1_r.bn;
    s2_nxt.fn = s1_r.fn;
    s2_nxt.fm = s1_r.fm;
  end

  // sum stage: exact dot, cross, sums of squares
  always_comb begin
    logic [5:0][65:0] sp;
    for (int k = 0; k < 6; k++) begin
      sp[k] = s2_r.pn[k] ? -{2'b00, s2_r.p[k]} : {2'b00, s2_r.p[k]};
    end
    s3_nxt.mode = s2_r.mode;
    for (int i = 0; i < 3; i++) begin
      if (s2_r.mode == MODE_CROSS) begin
        s3_nxt.v[i] = sp[2*i] - sp[2*i+1];
      end else begin
        s3_nxt.v[i] = sp[i];
      end
    end
    s3_nxt.dsum = sp[0] + sp[1] + sp[2];
    s3_nxt.sa   = s2_r.p[0] + s2_r.p[1] + s2_r.p[2];
    s3_nxt.nb   = s2_r.p[3] + s2_r.p[4] + s2_r.p[5];
    s3_nxt.asum = s2_r.asum;
    s3_nxt.a    = s2_r.a;
    s3_nxt.am   = s2_r.am;
    s3_nxt.bm   = s2_r.bm;
    s3_nxt.an   = s2_r.an;
    s3_nxt.bn   = s2_r.bn;
    s3_nxt.fn   = s2_r.fn;
    s3_nxt.fm   = s2_r.fm;
  end

  // shift, saturate the direct modes; dot in sign and magnitude for projection
  always_comb begin
    sat_t        t;
    logic [65:0] sh;
    logic [65:0] dneg_v;
    sq_in_nxt.c.res = '0;
    sq_in_nxt.c.ov  = 1'b0;
    t  = '0;
    sh = '0;
    unique case (s3_r.mode)
      MODE_ADD, MODE_SUB: begin
        for (int i = 0; i < 3; i++) begin
          t = sat32({{33{s3_r.asum[i][32]}}, s3_r.asum[i]});
          sq_in_nxt.c.res[i] = t.val;
          sq_in_nxt.c.ov     = sq_in_nxt.c.ov | t.ov;
        end
      end
      MODE_DOT: begin
        sh = $signed(s3_r.dsum) >>> FRAC_BITS;
        t  = sat32(sh);
        sq_in_nxt.c.res[3] = t.val;
        sq_in_nxt.c.ov     = t.ov;
      end
      MODE_CROSS, MODE_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          sh = $signed(s3_r.v[i]) >>> FRAC_BITS;
          t  = sat32(sh);
          sq_in_nxt.c.res[i] = t.val;
          sq_in_nxt.c.ov     = sq_in_nxt.c.ov | t.ov;
        end
      end
      default: ;
    endcase
    dneg_v              = -s3_r.dsum;
    sq_in_nxt.c.mode    = s3_r.mode;
    sq_in_nxt.c.a       = s3_r.a;
    sq_in_nxt.c.am      = s3_r.am;
    sq_in_nxt.c.bm      = s3_r.bm;
    sq_in_nxt.c.an      = s3_r.an;
    sq_in_nxt.c.bn      = s3_r.bn;
    sq_in_nxt.c.fn      = s3_r.fn;
    sq_in_nxt.c.fm      = s3_r.fm;
    sq_in_nxt.c.dneg    = s3_r.dsum[65];
    sq_in_nxt.c.dmag    = s3_r.dsum[65] ? dneg_v[63:0] : s3_r.dsum[63:0];
    sq_in_nxt.c.nb      = s3_r.nb;
    sq_in_nxt.x         = s3_r.sa;
    sq_in_nxt.r         = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r    <= s1_nxt;
      s2_r    <= s2_nxt;
      s3_r    <= s3_nxt;
      sq_in_r <= sq_in_nxt;
    end
  end

  // integer square root of a.a, one root bit per stage
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * k);
    sq_t         prv;
    logic [63:0] trial;
    if (k == 0) begin : g_first
      assign prv = sq_in_r;
    end else begin : g_next
      assign prv = sq_r[k-1];
    end
    assign trial = prv.r + SQ_BIT;
    always_comb begin
      sq_nxt[k] = prv;
      if (prv.x >= trial) begin
        sq_nxt[k].x = prv.x - trial;
        sq_nxt[k].r = (prv.r >> 1) + SQ_BIT;
      end else begin
        sq_nxt[k].r = prv.r >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[k] <= sq_nxt[k];
      end
    end
  end

  // partial products of |b_i| * |dot|, magnitude result
  always_comb begin
    sat_t t;
    m1_nxt.c   = sq_r[SQ_STEPS-1].c;
    m1_nxt.len = sq_r[SQ_STEPS-1].r[32:0];
    for (int i = 0; i < 3; i++) begin
      m1_nxt.pplo[i] = {32'd0, m1_nxt.c.bm[i]} * {32'd0, m1_nxt.c.dmag[31:0]};
      m1_nxt.pphi[i] = {32'd0, m1_nxt.c.bm[i]} * {32'd0, m1_nxt.c.dmag[63:32]};
    end
    t = sat32({33'd0, m1_nxt.len});
    if (m1_nxt.c.mode == MODE_MAG) begin
      m1_nxt.c.res[3] = t.val;
      m1_nxt.c.ov     = t.ov;
    end
  end

  // dividend and divisor selection
  always_comb begin
    m2_nxt.mode  = m1_r.c.mode;
    m2_nxt.res   = m1_r.c.res;
    m2_nxt.ov    = m1_r.c.ov;
    m2_nxt.a     = m1_r.c.a;
    m2_nxt.divop = 1'b1;
    m2_nxt.num   = '0;
    m2_nxt.den   = '0;
    m2_nxt.sgn   = '0;
    unique case (m1_r.c.mode)
      MODE_DIV: begin
        for (int i = 0; i < 3; i++) begin
          m2_nxt.num[i] = {64'd0, m1_r.c.am[i]} << FRAC_BITS;
        end
        m2_nxt.den = {32'd0, m1_r.c.fm};
        m2_nxt.sgn = m1_r.c.an ^ {3{m1_r.c.fn}};
      end
      MODE_UNIT: begin
        for (int i = 0; i < 3; i++) begin
          m2_nxt.num[i] = {64'd0, m1_r.c.am[i]} << FRAC_BITS;
        end
        m2_nxt.den = {31'd0, m1_r.len};
        m2_nxt.sgn = m1_r.c.an;
      end
      MODE_PROJ, MODE_PERP: begin
        for (int i = 0; i < 3; i++) begin
          m2_nxt.num[i] = {32'd0, m1_r.pplo[i]} + {m1_r.pphi[i], 32'd0};
        end
        m2_nxt.den = m1_r.c.nb;
        m2_nxt.sgn = m1_r.c.bn ^ {3{m1_r.c.dneg}};
      end
      default: m2_nxt.divop = 1'b0;
    endcase
    m2_nxt.dz = m2_nxt.divop && (m2_nxt.den == '0);
  end

  // divider setup: quotients wider than QBITS bits count as too large
  always_comb begin
    logic [63:0] hi;
    m3_nxt.mode  = m2_r.mode;
    m3_nxt.res   = m2_r.res;
    m3_nxt.ov    = m2_r.ov;
    m3_nxt.a     = m2_r.a;
    m3_nxt.divop = m2_r.divop;
    m3_nxt.dz    = m2_r.dz;
    m3_nxt.sgn   = m2_r.sgn;
    m3_nxt.den   = m2_r.den;
    hi           = '0;
    for (int i = 0; i < 3; i++) begin
      hi               = {{(QBITS-32){1'b0}}, m2_r.num[i][95:QBITS]};
      m3_nxt.big[i]    = hi >= m2_r.den;
      m3_nxt.rem[i]    = hi;
      m3_nxt.qw[i]     = m2_r.num[i][QBITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r <= m1_nxt;
      m2_r <= m2_nxt;
      m3_r <= m3_nxt;
    end
  end

  // restoring divider, three lanes, one quotient bit per stage
  for (genvar j = 0; j < QBITS; j++) begin : g_dv
    dv_t prv;
    if (j == 0) begin : g_first
      assign prv = m3_r;
    end else begin : g_next
      assign prv = dv_r[j-1];
    end
    always_comb begin
      logic [64:0] t;
      logic [64:0] d;
      logic        ge;
      dv_nxt[j] = prv;
      for (int i = 0; i < 3; i++) begin
        t  = {prv.rem[i], prv.qw[i][QBITS-1]};
        ge = t >= {1'b0, prv.den};
        d  = t - {1'b0, prv.den};
        dv_nxt[j].rem[i] = ge ? d[63:0] : t[63:0];
        dv_nxt[j].qw[i]  = {prv.qw[i][QBITS-2:0], ge};
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[j] <= dv_nxt[j];
      end
    end
  end

  // final sign, perpendicular difference, saturation, status
  always_comb begin
    dv_t         l;
    sat_t        t;
    logic [65:0] qv;
    logic [65:0] sv;
    logic        ov;
    logic        ndir;
    l  = dv_r[QBITS-1];
    ov = l.ov;
    t  = '0;
    qv = '0;
    sv = '0;
    ndir = 1'b0;
    out_nxt.r = l.res;
    if (l.divop) begin
      out_nxt.r[3] = '0;
      for (int i = 0; i < 3; i++) begin
        qv = {{(66-QBITS){1'b0}}, l.qw[i]};
        sv = l.sgn[i] ? -qv : qv;
        if (l.mode == MODE_PERP) begin
          sv   = {{34{l.a[i][31]}}, l.a[i]} - sv;
          ndir = !l.sgn[i];
        end else begin
          ndir = l.sgn[i];
        end
        if (l.big[i]) begin
          t.ov  = 1'b1;
          t.val = ndir ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          t = sat32(sv);
        end
        out_nxt.r[i] = t.val;
        ov = ov | t.ov;
      end
    end
    if (l.dz) begin
      out_nxt.r      = '0;
      out_nxt.status = ST_DIVZ;
    end else if (ov) begin
      out_nxt.status = ST_SAT;
    end else begin
      out_nxt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid    = vld_r[NST-1];
  assign out_ch.r_x      = out_r.r[0];
  assign out_ch.r_y      = out_r.r[1];
  assign out_ch.r_z      = out_r.r[2];
  assign out_ch.r_scalar = out_r.r[3];
  assign out_ch.status   = out_r.status;

  a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status == ST_DIVZ) |->
      (out_ch.r_x == '0) && (out_ch.r_y == '0) && (out_ch.r_z == '0) &&
      (out_ch.r_scalar == '0))
    else $error("division by zero item carries nonzero fields");

  a_root_width: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[V_M1-1] |-> (sq_r[SQ_STEPS-1].r[63:33] == '0))
    else $error("square root wider than 33 bits");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[V_DL] |->
      (dv_r[QBITS-1].big[0] || (dv_r[QBITS-1].rem[0] < dv_r[QBITS-1].den)) &&
      (dv_r[QBITS-1].big[1] || (dv_r[QBITS-1].rem[1] < dv_r[QBITS-1].den)) &&
      (dv_r[QBITS-1].big[2] || (dv_r[QBITS-1].rem[2] < dv_r[QBITS-1].den)))
    else $error("divider remainder not below divisor");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

endmodule
